// ===== rtl/aia_pkg.sv =====
// Shared constants and helpers for the accumulator integer ALU.
// Holds the data width, the operation codes and the magnitude helper.
// No dependencies.
package aia_pkg;

    localparam int DATA_W = 32;
    localparam int MODE_W = 3;
    localparam int CNT_W  = $clog2(DATA_W);

    typedef logic [DATA_W-1:0] t_word;
    typedef logic [MODE_W-1:0] t_mode;

    // Operation codes carried in the mode field.
    localparam t_mode MODE_ADD = 3'd0;
    localparam t_mode MODE_SUB = 3'd1;
    localparam t_mode MODE_MUL = 3'd2;
    localparam t_mode MODE_DIV = 3'd3;
    localparam t_mode MODE_POW = 3'd4;
    localparam t_mode MODE_MOD = 3'd5;

    // Absolute value of a two's complement word, wrapping for the most negative value.
    function automatic t_word mag(input t_word v);
        mag = v[DATA_W-1] ? (t_word'(0) - v) : v;
    endfunction

endpackage

// ===== rtl/accumulator_integer_alu.sv =====
// Sequence after acceptance: add, sub, mul and rejected requests go straight to the output load;
// div and modulo take 32 restoring steps, one sign fix and then the output load; power takes
// one zero test plus up to two shared 32x32 multiplies per exponent bit, then the output load.
// Requests are taken one at a time: the sequencer returns to idle as the result is loaded into the
// output register, and the output load waits while the output register is held by i_stall.
// Reset (i_rst_n, synchronous, active low) clears the sequencer, output valid and accumulator.
// Top level of the accumulator ALU; depends on aia_pkg.
module accumulator_integer_alu (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  aia_pkg::t_mode               i_mode,
    input  logic [aia_pkg::DATA_W-1:0]   i_operand_a,
    input  logic [aia_pkg::DATA_W-1:0]   i_operand_b,
    input  logic                         i_use_accumulator,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [aia_pkg::DATA_W-1:0]   o_value,
    output logic                         o_fault
);
    import aia_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_FIX  = 3'd2;
    localparam logic [2:0] S_POW  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0]       r_state, n_state;
    t_word            r_acc, n_acc;
    t_word            r_a, n_a;
    t_word            r_b, n_b;
    t_word            r_res, n_res;
    t_word            r_rem, n_rem;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_is_mod, n_is_mod;
    logic             r_neg, n_neg;
    logic             r_fault, n_fault;
    logic             r_out_valid, n_out_valid;
    t_word            r_out_value, n_out_value;
    logic             r_out_fault, n_out_fault;

    logic             accept;
    logic             out_free;
    t_word            a_sel;
    t_word            mul_x, mul_y, product;
    logic [DATA_W:0]  trial, diff;

    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;
    assign a_sel    = i_use_accumulator ? r_acc : i_operand_a;

    // Shared multiplier: operands come from the request or from the power loop.
    always_comb begin
        mul_x = a_sel;
        mul_y = i_operand_b;
        if (r_state == S_POW) begin
            mul_x = r_a;
            mul_y = r_b[0] ? r_res : r_a;
        end
    end
    assign product = t_word'(mul_x * mul_y);

    // One restoring division step: shift in the next dividend bit and try the subtract.
    assign trial = {r_rem, r_a[DATA_W-1]};
    assign diff  = trial - {1'b0, r_b};

    // Sequencer and datapath next state.
    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_a         = r_a;
        n_b         = r_b;
        n_res       = r_res;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_is_mod    = r_is_mod;
        n_neg       = r_neg;
        n_fault     = r_fault;
        n_out_valid = r_out_valid && i_stall;
        n_out_value = r_out_value;
        n_out_fault = r_out_fault;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_fault  = 1'b0;
                    n_res    = '0;
                    n_is_mod = (i_mode == MODE_MOD);
                    n_cnt    = CNT_W'(DATA_W - 1);
                    n_state  = S_FIN;
                    case (i_mode)
                        MODE_ADD: n_res = a_sel + i_operand_b;
                        MODE_SUB: n_res = a_sel - i_operand_b;
                        MODE_MUL: n_res = product;
                        MODE_DIV, MODE_MOD: begin
                            if (i_operand_b == '0) begin
                                n_fault = 1'b1;
                            end else begin
                                n_a     = mag(a_sel);
                                n_b     = mag(i_operand_b);
                                n_rem   = '0;
                                n_neg   = (i_mode == MODE_MOD) ? a_sel[DATA_W-1]
                                          : (a_sel[DATA_W-1] ^ i_operand_b[DATA_W-1]);
                                n_state = S_DIV;
                            end
                        end
                        MODE_POW: begin
                            if (a_sel == '0 && i_operand_b == '0) begin
                                n_fault = 1'b1;
                            end else if (i_operand_b[DATA_W-1]) begin
                                n_res = t_word'(1);
                            end else begin
                                n_res   = t_word'(1);
                                n_a     = a_sel;
                                n_b     = i_operand_b;
                                n_state = S_POW;
                            end
                        end
                        default: n_fault = 1'b1;
                    endcase
                end
            end

            // Quotient bits shift into r_a as the dividend bits shift out.
            S_DIV: begin
                if (!diff[DATA_W]) begin
                    n_rem = diff[DATA_W-1:0];
                end else begin
                    n_rem = trial[DATA_W-1:0];
                end
                n_a = {r_a[DATA_W-2:0], !diff[DATA_W]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIX;
                end
            end

            // Apply the sign to the quotient or the remainder.
            S_FIX: begin
                n_res   = r_is_mod ? r_rem : r_a;
                if (r_neg) begin
                    n_res = t_word'(0) - n_res;
                end
                n_state = S_FIN;
            end

            // Square-and-multiply: multiply in the low exponent bit, then square the base.
            S_POW: begin
                if (r_b == '0) begin
                    n_state = S_FIN;
                end else if (r_b[0]) begin
                    n_res = product;
                    n_b   = {r_b[DATA_W-1:1], 1'b0};
                end else begin
                    n_a = product;
                    n_b = r_b >> 1;
                end
            end

            // Hand the result to the output register and update the accumulator.
            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_value = r_fault ? '0 : r_res;
                    n_out_fault = r_fault;
                    n_acc       = r_fault ? '0 : r_res;
                    n_state     = S_IDLE;
                end
            end

            default: n_state = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_a         <= n_a;
        r_b         <= n_b;
        r_res       <= n_res;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_is_mod    <= n_is_mod;
        r_neg       <= n_neg;
        r_fault     <= n_fault;
        r_out_value <= n_out_value;
        r_out_fault <= n_out_fault;
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_value = r_out_value;
    assign o_fault = r_out_fault;

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the accumulator integer ALU (accumulator_integer_alu).
// Depends on aia_pkg and the RTL top; predicts each result and checks it in order.
module tb_top;
    import aia_pkg::*;

    // Mode codes that the block does not define; both must be rejected.
    localparam t_mode MODE_BAD6 = 3'd6;
    localparam t_mode MODE_BAD7 = 3'd7;

    localparam int QUIET_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 80;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        t_word value;
        logic  fault;
    } t_alu_out;

    logic  i_clk;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_stall;
    t_mode i_mode = MODE_ADD;
    t_word i_operand_a = '0;
    t_word i_operand_b = '0;
    logic  i_use_accumulator = 1'b0;
    logic  o_valid;
    logic  i_stall = 1'b0;
    t_word o_value;
    logic  o_fault;

    t_alu_out expected_results[$];
    t_word    acc_model = '0;
    int       fail_count = 0;
    int       send_idle_pct = 0;
    int       stall_pct = 0;
    int       hold_asked = 0;
    int       hold_seen = 0;
    int       hold_left = 0;
    int       quiet_cycles = 0;

    accumulator_integer_alu DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_mode            (i_mode),
        .i_operand_a       (i_operand_a),
        .i_operand_b       (i_operand_b),
        .i_use_accumulator (i_use_accumulator),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_value           (o_value),
        .o_fault           (o_fault)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Square-and-multiply power with 32-bit wrap; a negative exponent gives 1.
    function automatic t_word wrap_power(input t_word base, input t_word expo);
        t_word acc;
        acc = 32'd1;
        if (expo[DATA_W-1]) begin
            return acc;
        end
        while (expo != 0) begin
            if (expo[0]) begin
                acc = acc * base;
            end
            base = base * base;
            expo = expo >> 1;
        end
        return acc;
    endfunction

    // Expected value and fault flag for one request, given the current accumulator.
    function automatic t_alu_out predict_alu(input t_mode op, input t_word a_in,
                                             input t_word b, input logic use_acc,
                                             input t_word acc);
        t_alu_out r;
        t_word    a;
        t_word    a_abs;
        t_word    b_abs;
        a     = use_acc ? acc : a_in;
        a_abs = a[DATA_W-1] ? (~a + 1'b1) : a;
        b_abs = b[DATA_W-1] ? (~b + 1'b1) : b;
        r.value = '0;
        r.fault = 1'b0;
        case (op)
            MODE_ADD: r.value = a + b;
            MODE_SUB: r.value = a - b;
            MODE_MUL: r.value = a * b;
            MODE_DIV: begin
                if (b == 0) begin
                    r.fault = 1'b1;
                end else begin
                    // Truncate toward zero: divide magnitudes, then fix the sign.
                    r.value = a_abs / b_abs;
                    if (a[DATA_W-1] ^ b[DATA_W-1]) begin
                        r.value = ~r.value + 1'b1;
                    end
                end
            end
            MODE_POW: begin
                if (a == 0 && b == 0) begin
                    r.fault = 1'b1;
                end else begin
                    r.value = wrap_power(a, b);
                end
            end
            MODE_MOD: begin
                if (b == 0) begin
                    r.fault = 1'b1;
                end else begin
                    // The remainder follows the sign of the dividend.
                    r.value = a_abs % b_abs;
                    if (a[DATA_W-1]) begin
                        r.value = ~r.value + 1'b1;
                    end
                end
            end
            default: r.fault = 1'b1;
        endcase
        if (r.fault) begin
            r.value = '0;
        end
        return r;
    endfunction

    // Offer one request, wait for it to be taken, then record its expected result.
    task automatic send_request(input t_mode op, input t_word a, input t_word b,
                                input logic use_acc);
        t_alu_out r;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid           <= 1'b1;
        i_mode            <= op;
        i_operand_a       <= a;
        i_operand_b       <= b;
        i_use_accumulator <= use_acc;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        r = predict_alu(op, a, b, use_acc, acc_model);
        acc_model = r.value;
        expected_results.push_back(r);
    endtask

    // Stop offering requests and wait until every pending result has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Operand biased toward boundary values, with full-range random values too.
    function automatic t_word pick_operand();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return 32'h7FFF_FFFF;
            5: return t_word'($urandom_range(40)) - 32'd20;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_request();
        t_mode op;
        t_word b;
        if ($urandom_range(99) < 4) begin
            op = $urandom_range(1) ? MODE_BAD6 : MODE_BAD7;
        end else begin
            op = t_mode'($urandom_range(MODE_MOD));
        end
        b = pick_operand();
        // Keep most exponents small so the power results stay interesting.
        if (op == MODE_POW && $urandom_range(99) < 70) begin
            b = t_word'($urandom_range(40)) - ($urandom_range(9) == 0 ? 32'd20 : 32'd0);
        end
        send_request(op, pick_operand(), b, 1'($urandom_range(1)));
    endtask

    // Boundary values, every operation and every rejected case.
    task automatic test_directed();
        send_idle_pct = 0;
        stall_pct     = 0;
        send_request(MODE_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 1'b0);
        send_request(MODE_ADD, 32'h8000_0000, 32'h8000_0000, 1'b0);
        send_request(MODE_SUB, 32'h8000_0000, 32'h0000_0001, 1'b0);
        send_request(MODE_SUB, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0);
        send_request(MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_request(MODE_MUL, 32'hFFFF_FFFF, 32'h8000_0000, 1'b0);
        send_request(MODE_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_DIV, 32'hFFFF_FFF9, 32'h0000_0002, 1'b0);
        send_request(MODE_DIV, 32'h0000_0007, 32'hFFFF_FFFE, 1'b0);
        send_request(MODE_DIV, 32'h0000_0005, 32'h0000_0000, 1'b0);
        send_request(MODE_MOD, 32'hFFFF_FFF9, 32'h0000_0002, 1'b0);
        send_request(MODE_MOD, 32'h0000_0007, 32'hFFFF_FFFE, 1'b0);
        send_request(MODE_MOD, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_MOD, 32'h0000_0003, 32'h0000_0000, 1'b0);
        send_request(MODE_POW, 32'h0000_0000, 32'h0000_0000, 1'b0);
        send_request(MODE_POW, 32'h0000_0003, 32'hFFFF_FFFF, 1'b0);
        send_request(MODE_POW, 32'h0000_0002, 32'h0000_001F, 1'b0);
        send_request(MODE_POW, 32'h0000_0002, 32'h0000_0020, 1'b0);
        send_request(MODE_POW, 32'h0000_0000, 32'h0000_0007, 1'b0);
        send_request(MODE_POW, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b0);
        send_request(MODE_BAD6, 32'h0000_0011, 32'h0000_0022, 1'b0);
        send_request(MODE_BAD7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // Accumulator is now zero: zero to the power zero through the accumulator.
        send_request(MODE_POW, 32'h1234_5678, 32'h0000_0000, 1'b1);
        send_request(MODE_ADD, $urandom, 32'h0000_0005, 1'b1);
        send_request(MODE_MUL, $urandom, 32'hFFFF_FFFD, 1'b1);
        send_request(MODE_POW, $urandom, 32'h0000_0002, 1'b1);
    endtask

    // Random requests under one idling profile.
    task automatic test_random_traffic(input int count, input int idle_pct,
                                       input int busy_pct);
        send_idle_pct = idle_pct;
        stall_pct     = busy_pct;
        repeat (count) begin
            send_random_request();
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_backpressure_hold();
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_asked    = hold_asked + 1;
        repeat (30) begin
            send_random_request();
        end
    endtask

    // Requests stop until every result is back, then traffic resumes.
    task automatic test_drain_pause();
        send_idle_pct = 15;
        stall_pct     = 15;
        repeat (20) begin
            send_random_request();
        end
        drain_results();
        repeat (20) begin
            send_random_request();
        end
    endtask

    // Receiver side: random stall, or a long hold when one is requested.
    always @(posedge i_clk) begin
        if (hold_asked != hold_seen) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Compare each accepted result with the oldest pending expectation.
    always @(posedge i_clk) begin
        t_alu_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                fail_count = fail_count + 1;
                if (fail_count <= MAX_REPORTS) begin
                    $display("unexpected result: value %h fault %b", o_value, o_fault);
                end
            end else begin
                want = expected_results.pop_front();
                if (want.value !== o_value || want.fault !== o_fault) begin
                    fail_count = fail_count + 1;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("mismatch: value exp %h got %h, fault exp %b got %b",
                                 want.value, o_value, want.fault, o_fault);
                    end
                end
            end
        end
    end

    // Watchdog: too long without any handshake ends the run.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_traffic(400, 0, 0);
        test_random_traffic(400, 57, 0);
        test_random_traffic(400, 0, 57);
        test_random_traffic(400, 15, 15);
        test_backpressure_hold();
        test_drain_pause();
        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        fail_count = fail_count + expected_results.size();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
